FILE: sv/plist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list package
// Codes, field widths, the name record and the controller states shared by
// the positional list block and its channel interfaces.
// ----------------------------------------------------------------------------
package plist_pkg;

   // Field widths of the channel payloads.
   localparam int ACTION_W = 2;
   localparam int POS_W    = 8;
   localparam int WORD_W   = 64;
   localparam int TAIL_W   = 40;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BOUNDS = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

   // One stored name: four words, first character in the lowest byte of word a.
   typedef struct packed {
      logic [TAIL_W-1:0] word_d;
      logic [WORD_W-1:0] word_c;
      logic [WORD_W-1:0] word_b;
      logic [WORD_W-1:0] word_a;
   } name_type;

   localparam int NAME_W = $bits(name_type);

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_RD_ADDR,
      ST_RD_DATA
   } state_type;

endpackage : plist_pkg
`default_nettype wire

FILE: sv/plist_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list channel interfaces
// Request and response channels with a valid/ready handshake and the payload.
// ----------------------------------------------------------------------------
interface plist_req_if
   import plist_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [POS_W-1:0]    position;
   logic [WORD_W-1:0]   name_word_a;
   logic [WORD_W-1:0]   name_word_b;
   logic [WORD_W-1:0]   name_word_c;
   logic [TAIL_W-1:0]   name_word_d;

   modport source (
      output valid, action, position, name_word_a, name_word_b, name_word_c,
             name_word_d,
      input  ready
   );

   modport sink (
      input  valid, action, position, name_word_a, name_word_b, name_word_c,
             name_word_d,
      output ready
   );
endinterface : plist_req_if

interface plist_rsp_if
   import plist_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    entry_position;
   logic [WORD_W-1:0]   out_word_a;
   logic [WORD_W-1:0]   out_word_b;
   logic [WORD_W-1:0]   out_word_c;
   logic [TAIL_W-1:0]   out_word_d;
   logic [LEN_W-1:0]    list_length;
   logic                last;

   modport source (
      output valid, status, entry_position, out_word_a, out_word_b, out_word_c,
             out_word_d, list_length, last,
      input  ready
   );

   modport sink (
      input  valid, status, entry_position, out_word_a, out_word_b, out_word_c,
             out_word_d, list_length, last,
      output ready
   );
endinterface : plist_rsp_if
`default_nettype wire

FILE: sv/positional_list_insert_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list insert/delete
// Ordered list of names held in one RAM. Insert and delete shift the entries
// behind the chosen position through the RAM; read-out streams every entry.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Beat
//   req_chan   in         action, position, four name words
//   rsp_chan   out        status, entry position, four name words, length, last
//
// An insert or delete beat has its response beat loaded at acceptance; the
// entries behind the position then move one RAM read and one RAM write per
// cycle, and no new beat is taken until the move ends. A refused insert or
// delete moves nothing. A read-out reads each entry in ST_RD_ADDR and loads
// it into the response in ST_RD_DATA, behind the RAM's registered read port.
// Reset clears the controller and the entry count; the RAM needs no clearing
// pass because only entries below the count are ever read.
// A stalled response holds the payload; no new beat is taken until it drains.
//
module positional_list_insert_delete
   import plist_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   plist_req_if.sink  req_chan,
   plist_rsp_if.source rsp_chan
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // Controller registers.
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     src_ff, src_in;
   logic [CW-1:0]     dst_ff, dst_in;
   logic [CW-1:0]     moves_ff, moves_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pdst_ff, pdst_in;
   logic              ins_ff, ins_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   name_type          name_ff, name_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   name_type          rsp_name_ff, rsp_name_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;

   // RAM port signals.
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   name_type          ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   name_type          ram_rd_data;

   // Decoded request.
   logic              accept;
   logic              out_free;
   logic              is_empty;
   logic              is_full;
   logic              pos_past;
   logic [CW-1:0]     ins_slot;
   logic [CW-1:0]     next_idx;

   plist_ram #(
      .WIDTH (NAME_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Handshake and request decode.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign pos_past = CMPW'(req_chan.position) > CMPW'(count_ff);
   assign next_idx = rd_idx_ff + CW'(1);

   // Insert slot: front for position 0 or 1 or an empty list, end past the count.
   always_comb begin
      if (req_chan.position <= POS_W'(1) || is_empty) begin
         ins_slot = '0;
      end else if (pos_past) begin
         ins_slot = count_ff;
      end else begin
         ins_slot = CW'(CMPW'(req_chan.position) - CMPW'(1));
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.action)
                  ACT_INSERT: begin
                     if (!is_full) begin
                        state_in = ST_MOVE;
                     end
                  end
                  ACT_DELETE: begin
                     if (!is_empty && req_chan.position != '0 && !pos_past) begin
                        state_in = ST_MOVE;
                     end
                  end
                  ACT_READ: begin
                     if (!is_empty) begin
                        state_in = ST_RD_ADDR;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MOVE: begin
            if (moves_ff == '0 && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (out_free) begin
               state_in = (next_idx == count_ff) ? ST_IDLE : ST_RD_ADDR;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, RAM control and response loading.
   always_comb begin
      count_in      = count_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      moves_in      = moves_ff;
      pend_in       = 1'b0;
      pdst_in       = pdst_ff;
      ins_in        = ins_ff;
      rd_idx_in     = rd_idx_ff;
      name_in       = name_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_name_in   = rsp_name_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pdst_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = src_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               name_in = '{word_d: req_chan.name_word_d, word_c: req_chan.name_word_c,
                           word_b: req_chan.name_word_b, word_a: req_chan.name_word_a};
               rsp_pos_in  = '0;
               rsp_name_in = '0;
               rsp_last_in = 1'b1;
               rsp_len_in  = LEN_W'(count_ff);
               case (req_chan.action)
                  ACT_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        rsp_len_in    = LEN_W'(count_ff + CW'(1));
                        count_in      = count_ff + CW'(1);
                        ins_in        = 1'b1;
                        moves_in      = count_ff - ins_slot;
                        src_in        = count_ff - CW'(1);
                        dst_in        = count_ff;
                     end
                  end
                  ACT_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (req_chan.position == '0 || pos_past) begin
                        rsp_status_in = STATUS_BOUNDS;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        rsp_len_in    = LEN_W'(count_ff - CW'(1));
                        count_in      = count_ff - CW'(1);
                        ins_in        = 1'b0;
                        moves_in      = count_ff - CW'(req_chan.position);
                        src_in        = CW'(req_chan.position);
                        dst_in        = CW'(req_chan.position) - CW'(1);
                     end
                  end
                  ACT_READ: begin
                     rd_idx_in = '0;
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                  end
               endcase
            end
         end

         // Shift engine: read one entry, write it one place over next cycle;
         // an insert then writes the new name into the opened slot.
         ST_MOVE: begin
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pdst_ff;
               ram_wr_data = ram_rd_data;
            end else if (moves_ff == '0 && ins_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = dst_ff[AW-1:0];
               ram_wr_data = name_ff;
            end
            if (moves_ff != '0) begin
               pend_in  = 1'b1;
               pdst_in  = dst_ff[AW-1:0];
               moves_in = moves_ff - CW'(1);
               if (ins_ff) begin
                  src_in = src_ff - CW'(1);
                  dst_in = dst_ff - CW'(1);
               end else begin
                  src_in = src_ff + CW'(1);
                  dst_in = dst_ff + CW'(1);
               end
            end
         end

         ST_RD_ADDR: begin
            ram_rd_addr = rd_idx_ff[AW-1:0];
         end

         // Hold the read address so the RAM output stays put through a stall.
         ST_RD_DATA: begin
            ram_rd_addr = rd_idx_ff[AW-1:0];
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_pos_in    = POS_W'(next_idx);
               rsp_name_in   = ram_rd_data;
               rsp_len_in    = LEN_W'(count_ff);
               rsp_last_in   = (next_idx == count_ff);
               rd_idx_in     = next_idx;
            end
         end

         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and cursor registers.
   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      moves_ff      <= moves_in;
      pdst_ff       <= pdst_in;
      ins_ff        <= ins_in;
      rd_idx_ff     <= rd_idx_in;
      name_ff       <= name_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Response channel.
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.entry_position = rsp_pos_ff;
   assign rsp_chan.out_word_a     = rsp_name_ff.word_a;
   assign rsp_chan.out_word_b     = rsp_name_ff.word_b;
   assign rsp_chan.out_word_c     = rsp_name_ff.word_c;
   assign rsp_chan.out_word_d     = rsp_name_ff.word_d;
   assign rsp_chan.list_length    = rsp_len_ff;
   assign rsp_chan.last           = rsp_last_ff;

endmodule : positional_list_insert_delete
`default_nettype wire

FILE: sv/plist_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module plist_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : plist_ram
`default_nettype wire
